@@ sv/morse_text_decoder_assert.svh @@
// Assertion macros for the Morse text decoder checker.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef MORSE_TEXT_DECODER_ASSERT_SVH
`define MORSE_TEXT_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MTD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("morse_text_decoder: assertion failed");

// Next-cycle implication, disabled during reset.
`define MTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("morse_text_decoder: assertion failed");

`endif

@@ sv/mtd_pkg.sv @@
// Package for the Morse text decoder: character codes and the letter table.
// No dependencies; imported by the top level.
package mtd_pkg;

   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharDot   = 8'h2E;
   localparam logic [7:0] CharDash  = 8'h2D;
   localparam logic [7:0] CharNone  = 8'h00;

   localparam int LenWidth     = 4;
   localparam int PatternWidth = 8;

   // Symbol i of the letter in bit i, 1 for a dash; CharNone when unmatched.
   function automatic logic [7:0] mtd_lookup(input logic [LenWidth-1:0] len,
                                             input logic [PatternWidth-1:0] bits);
      logic [7:0] chr;
      unique case ({len, bits})
         {4'd2, 8'd2}:  chr = "a";
         {4'd4, 8'd1}:  chr = "b";
         {4'd4, 8'd5}:  chr = "c";
         {4'd3, 8'd1}:  chr = "d";
         {4'd1, 8'd0}:  chr = "e";
         {4'd4, 8'd4}:  chr = "f";
         {4'd3, 8'd3}:  chr = "g";
         {4'd4, 8'd0}:  chr = "h";
         {4'd2, 8'd0}:  chr = "i";
         {4'd4, 8'd14}: chr = "j";
         {4'd3, 8'd5}:  chr = "k";
         {4'd4, 8'd2}:  chr = "l";
         {4'd2, 8'd3}:  chr = "m";
         {4'd2, 8'd1}:  chr = "n";
         {4'd3, 8'd7}:  chr = "o";
         {4'd4, 8'd6}:  chr = "p";
         {4'd4, 8'd11}: chr = "q";
         {4'd3, 8'd2}:  chr = "r";
         {4'd3, 8'd0}:  chr = "s";
         {4'd1, 8'd1}:  chr = "t";
         {4'd3, 8'd4}:  chr = "u";
         {4'd4, 8'd8}:  chr = "v";
         {4'd3, 8'd6}:  chr = "w";
         {4'd4, 8'd9}:  chr = "x";
         {4'd4, 8'd13}: chr = "y";
         {4'd4, 8'd3}:  chr = "z";
         {4'd5, 8'd31}: chr = "0";
         {4'd5, 8'd30}: chr = "1";
         {4'd5, 8'd28}: chr = "2";
         {4'd5, 8'd24}: chr = "3";
         {4'd5, 8'd16}: chr = "4";
         {4'd5, 8'd0}:  chr = "5";
         {4'd5, 8'd1}:  chr = "6";
         {4'd5, 8'd3}:  chr = "7";
         {4'd5, 8'd7}:  chr = "8";
         {4'd5, 8'd15}: chr = "9";
         {4'd6, 8'd42}: chr = ".";
         {4'd6, 8'd33}: chr = "-";
         {4'd6, 8'd51}: chr = ",";
         {4'd6, 8'd53}: chr = "!";
         {4'd6, 8'd12}: chr = "?";
         {4'd6, 8'd30}: chr = 8'h27;
         {4'd6, 8'd18}: chr = 8'h22;
         default:       chr = CharNone;
      endcase
      return chr;
   endfunction

endpackage

@@ sv/mtd_req_if.sv @@
// Input channel of the Morse text decoder: valid/ready with one text character.
// No dependencies.
interface mtd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_char;
   logic       end_of_text;

   modport source (output valid, output code_char, output end_of_text, input ready);
   modport sink   (input valid, input code_char, input end_of_text, output ready);
endinterface

@@ sv/mtd_rsp_if.sv @@
// Result channel of the Morse text decoder: valid/ready with one decoded character.
// No dependencies.
interface mtd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] plain_char;
   logic       unknown_code;

   modport source (output valid, output plain_char, output unknown_code, input ready);
   modport sink   (input valid, input plain_char, input unknown_code, output ready);
endinterface

@@ sv/morse_text_decoder.sv @@
// Morse text decoder: takes one character of Morse text per item and gives one
// decoded character per finished letter or word gap. Uses mtd_pkg, mtd_req_if, mtd_rsp_if.
//
// Rate: one item per clock cycle while req_ch.ready is high. Each item updates the
// letter state and matches the table in combinational logic ahead of the result
// register, so a result appears in the cycle after its item; req_ch.ready stays high
// while the result register is empty or being drained. A space ends a letter; every
// third space in a row gives 0x20; end_of_text flushes a pending letter and clears all
// state. Unknown, overlong or stray-marked letters give 0 with unknown_code set. Spaces
// with nothing pending give no result until they make a word gap.
module morse_text_decoder
   import mtd_pkg::*;
#(
   parameter int MAX_SYMBOLS = 6
) (
   input  logic       clock,
   input  logic       reset,
   mtd_req_if.sink    req_ch,
   mtd_rsp_if.source  rsp_ch
);

   localparam int CountWidth = $clog2(MAX_SYMBOLS + 1);

   logic [MAX_SYMBOLS-1:0] pattern_ff, pattern_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   bad_ff, bad_in;
   logic [1:0]             run_ff, run_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             plain_ff, plain_in;
   logic                   unknown_ff, unknown_in;

   logic                   accept;
   logic                   is_space;
   logic                   is_dot;
   logic                   is_dash;
   logic [MAX_SYMBOLS-1:0] sym_pattern;
   logic [CountWidth-1:0]  sym_count;
   logic                   sym_bad;
   logic [MAX_SYMBOLS-1:0] src_pattern;
   logic [CountWidth-1:0]  src_count;
   logic                   src_bad;
   logic [7:0]             letter_char;
   logic                   pending_cur;
   logic                   pending_sym;
   logic                   word_gap;
   logic                   emit_letter;
   logic                   out_free;

   assign out_free      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready  = out_free;
   assign accept        = req_ch.valid && out_free;

   assign is_space = req_ch.code_char == CharSpace;
   assign is_dot   = req_ch.code_char == CharDot;
   assign is_dash  = req_ch.code_char == CharDash;

   always_comb begin
      sym_pattern = pattern_ff;
      sym_count   = count_ff;
      sym_bad     = bad_ff;
      if (is_dot || is_dash) begin
         if (count_ff < CountWidth'(MAX_SYMBOLS)) begin
            for (int i = 0; i < MAX_SYMBOLS; i++) begin
               if (CountWidth'(i) == count_ff) begin
                  sym_pattern[i] = is_dash;
               end
            end
            sym_count = count_ff + CountWidth'(1);
         end else begin
            sym_bad = 1'b1;
         end
      end else begin
         sym_bad = 1'b1;
      end
   end

   assign pending_cur = (count_ff != '0) || bad_ff;
   assign pending_sym = (sym_count != '0) || sym_bad;

   assign src_pattern = is_space ? pattern_ff : sym_pattern;
   assign src_count   = is_space ? count_ff : sym_count;
   assign src_bad     = is_space ? bad_ff : sym_bad;

   assign letter_char = (src_bad || src_count == '0) ? CharNone :
                        mtd_lookup(LenWidth'(src_count), PatternWidth'(src_pattern));

   assign word_gap    = is_space && (run_ff == 2'd2);
   assign emit_letter = is_space ? pending_cur : (req_ch.end_of_text && pending_sym);

   always_comb begin
      pattern_in = pattern_ff;
      count_in   = count_ff;
      bad_in     = bad_ff;
      run_in     = run_ff;
      if (accept) begin
         if (req_ch.end_of_text) begin
            pattern_in = '0;
            count_in   = '0;
            bad_in     = 1'b0;
            run_in     = 2'd0;
         end else if (is_space) begin
            pattern_in = '0;
            count_in   = '0;
            bad_in     = 1'b0;
            run_in     = word_gap ? 2'd0 : run_ff + 2'd1;
         end else begin
            pattern_in = sym_pattern;
            count_in   = sym_count;
            bad_in     = sym_bad;
            run_in     = 2'd0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      plain_in     = plain_ff;
      unknown_in   = unknown_ff;
      if (out_free) begin
         rsp_valid_in = accept && (emit_letter || word_gap);
         if (word_gap) begin
            plain_in   = CharSpace;
            unknown_in = 1'b0;
         end else begin
            plain_in   = letter_char;
            unknown_in = letter_char == CharNone;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= '0;
         count_ff     <= '0;
         bad_ff       <= 1'b0;
         run_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pattern_ff   <= pattern_in;
         count_ff     <= count_in;
         bad_ff       <= bad_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plain_ff   <= plain_in;
      unknown_ff <= unknown_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.plain_char   = plain_ff;
   assign rsp_ch.unknown_code = unknown_ff;

endmodule

@@ sv/mtd_checker.sv @@
// Port checker for the Morse text decoder, bound to the top level.
// Uses morse_text_decoder_assert.svh for the assertion macros.
`include "morse_text_decoder_assert.svh"

module mtd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] plain_char,
   input logic       unknown_code
);

   `MTD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(plain_char) && $stable(unknown_code))
   `MTD_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)
   `MTD_ASSERT_NEXT(a_no_invented_item, clock, reset, !(req_valid && req_ready) && !rsp_valid, !rsp_valid)
   `MTD_ASSERT_NOW(a_unknown_is_zero, clock, reset, rsp_valid && unknown_code, plain_char == 8'h00)
   `MTD_ASSERT_NOW(a_known_not_zero, clock, reset, rsp_valid && !unknown_code, plain_char != 8'h00)

endmodule

bind morse_text_decoder mtd_checker u_mtd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .plain_char   (rsp_ch.plain_char),
   .unknown_code (rsp_ch.unknown_code)
);
